FILE: hw/rtl/apr_pkg.sv
// Shared types and constants of the ARP learning proxy responder.
// Used by the controller, the datapath and the top level; depends on nothing.
package apr_pkg;

  // Default number of entries in the seen-MAC set and in the IP map.
  localparam int unsigned TableDepthDefault = 64;

  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] OpRequest    = 16'h0001;

  typedef enum logic [1:0] {
    VERDICT_IGNORED  = 2'd0,
    VERDICT_LEARNED  = 2'd1,
    VERDICT_ANSWERED = 2'd2,
    VERDICT_FLOOD    = 2'd3
  } apr_verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAC_SCAN,
    ST_KEY_SCAN,
    ST_WRITE,
    ST_LOOKUP,
    ST_FINISH
  } apr_state_e;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] source_mac;
    logic [15:0] ingress_port;
    logic [7:0]  switch_tag;
  } apr_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_target_ip;
    logic [47:0] reply_target_mac;
    logic [15:0] egress_port;
    logic [7:0]  switch_out;
    logic [31:0] answered_total;
    logic [31:0] flooded_total;
    logic        table_full;
  } apr_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic scan_mac;
    logic learn;
    logic lookup;
    logic finish;
  } apr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_arp;
    logic is_req;
    logic scan_done;
  } apr_status_t;

endpackage

FILE: hw/rtl/arp_learning_proxy_responder_unit.sv
// A request runs through decode, the seen-MAC scan, the IP-map scan, the learning write,
// the lookup read and the result step; other ARP words skip the lookup read, and non-ARP
// words go straight from decode to the result step. The two sequential table scans, one
// RAM read per cycle, lengthen as the tables fill. One word is in work at a time; a new word may
// start in the strobe cycle. The receiver cannot stall. Reset is asynchronous, active low:
// it clears the fill levels and counters; table contents stay undefined, with no clear pass.
module arp_learning_proxy_responder_unit
  import apr_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  apr_item_t   item_i,
  output logic        busy_o,
  output logic        done_o,
  output apr_result_t result_o
);

  // The controller sequences one word through decode, the seen-MAC scan, the IP-map
  // scan (which looks for both the sender IP and the target IP in one pass), the
  // learning write, the value read for a request, and the result step.
  // The datapath holds the tables, the scan engine and the running counters.

  apr_cmd_t    cmd;
  apr_status_t status;

  apr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  apr_datapath #(.TableDepth(TableDepth)) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o),
    .done_o   (done_o)
  );

`ifndef SYNTHESIS
  // An accepted word always keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

  // A result is shown only once the controller has gone back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while the controller is still busy");

  // Two results never come in back-to-back cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

FILE: hw/rtl/apr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for every table of the responder.
module apr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/apr_ctrl.sv
// Controller state machine of the ARP learning proxy responder.
// Depends on apr_pkg for the state enum and the command and status structs.
module apr_ctrl
  import apr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  apr_status_t status_i,
  output apr_cmd_t    cmd_o,
  output logic        busy_o
);

  apr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = status_i.is_arp ? ST_MAC_SCAN : ST_FINISH;
      end
      ST_MAC_SCAN: begin
        if (status_i.scan_done) state_d = ST_KEY_SCAN;
      end
      ST_KEY_SCAN: begin
        if (status_i.scan_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = status_i.is_req ? ST_LOOKUP : ST_FINISH;
      end
      ST_LOOKUP: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_MAC_SCAN: begin
        cmd_o.scan_en  = 1'b1;
        cmd_o.scan_mac = 1'b1;
      end
      ST_KEY_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.learn = 1'b1;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/apr_datapath.sv
// Datapath of the ARP learning proxy responder: tables, scan engine, counters.
// Depends on apr_pkg and instantiates apr_ram for the three tables.
module apr_datapath
  import apr_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  apr_item_t   item_i,
  input  apr_cmd_t    cmd_i,
  output apr_status_t status_o,
  output apr_result_t result_o,
  output logic        done_o
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);

  apr_item_t   item_q;
  apr_result_t result_q, result_d;
  logic        done_q;

  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          pend_q;
  logic [AW-1:0] cmp_idx_q;
  logic          mac_found_q, s_found_q, t_found_q, full_q;
  logic [AW-1:0] s_idx_q, t_idx_q;
  logic [CW-1:0] seen_count_q, map_count_q;
  logic [31:0]   ans_q, ans_d, fld_q, fld_d;

  logic [47:0] seen_rdata, val_rdata;
  logic [31:0] key_rdata;

  logic [CW-1:0] limit;
  logic          mac_hit, s_hit, t_hit, scan_done, issue;
  logic          is_arp, is_req;
  logic          seen_full, map_full, drop, do_ins;
  logic [AW-1:0] val_slot;
  logic          t_new;

  assign is_arp = (item_q.ether_type == EtherTypeArp);
  assign is_req = (item_q.arp_opcode == OpRequest);

  // Scan engine: one table read issued per cycle, compared in the next cycle.
  assign limit     = cmd_i.scan_mac ? seen_count_q : map_count_q;
  assign mac_hit   = pend_q && (seen_rdata == item_q.source_mac);
  assign s_hit     = pend_q && (key_rdata == item_q.sender_ip);
  assign t_hit     = pend_q && (key_rdata == item_q.target_ip);
  assign scan_done = cmd_i.scan_en &&
                     ((cmd_i.scan_mac && mac_hit) || (rd_idx_q >= limit));
  assign issue     = cmd_i.scan_en && !scan_done;
  assign rd_idx_d  = issue ? rd_idx_q + CW'(1) : '0;

  // Learning decision, taken in the write step.
  assign seen_full = (seen_count_q == CW'(TableDepth));
  assign map_full  = (map_count_q == CW'(TableDepth));
  assign drop      = !mac_found_q && (seen_full || (!s_found_q && map_full));
  assign do_ins    = cmd_i.learn && !mac_found_q && !drop;
  assign val_slot  = s_found_q ? s_idx_q : map_count_q[AW-1:0];
  // A fresh binding for the target IP itself makes the lookup succeed.
  assign t_new     = do_ins && !s_found_q && !t_found_q &&
                     (item_q.target_ip == item_q.sender_ip);

  apr_ram #(.Width(48), .Depth(TableDepth)) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (do_ins),
    .waddr_i (seen_count_q[AW-1:0]),
    .wdata_i (item_q.source_mac),
    .re_i    (issue && cmd_i.scan_mac),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (seen_rdata)
  );

  apr_ram #(.Width(32), .Depth(TableDepth)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (do_ins && !s_found_q),
    .waddr_i (map_count_q[AW-1:0]),
    .wdata_i (item_q.sender_ip),
    .re_i    (issue && !cmd_i.scan_mac),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  apr_ram #(.Width(48), .Depth(TableDepth)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (do_ins),
    .waddr_i (val_slot),
    .wdata_i (item_q.source_mac),
    .re_i    (cmd_i.lookup),
    .raddr_i (t_idx_q),
    .rdata_o (val_rdata)
  );

  always_comb begin
    result_d = '0;
    ans_d    = ans_q;
    fld_d    = fld_q;
    result_d.verdict = VERDICT_IGNORED;
    if (is_arp) begin
      result_d.verdict    = VERDICT_LEARNED;
      result_d.table_full = full_q;
      if (is_req) begin
        result_d.switch_out = item_q.switch_tag;
        if (t_found_q) begin
          result_d.verdict          = VERDICT_ANSWERED;
          result_d.reply_sender_ip  = item_q.target_ip;
          result_d.reply_sender_mac = val_rdata;
          result_d.reply_target_ip  = item_q.sender_ip;
          result_d.reply_target_mac = item_q.source_mac;
          result_d.egress_port      = item_q.ingress_port;
          ans_d = ans_q + 32'd1;
        end else begin
          result_d.verdict = VERDICT_FLOOD;
          fld_d = fld_q + 32'd1;
        end
      end
    end
    result_d.answered_total = ans_d;
    result_d.flooded_total  = fld_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      pend_q       <= 1'b0;
      mac_found_q  <= 1'b0;
      s_found_q    <= 1'b0;
      t_found_q    <= 1'b0;
      full_q       <= 1'b0;
      seen_count_q <= '0;
      map_count_q  <= '0;
      ans_q        <= '0;
      fld_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      pend_q   <= issue;
      done_q   <= cmd_i.finish;
      if (cmd_i.load) begin
        mac_found_q <= 1'b0;
        s_found_q   <= 1'b0;
        t_found_q   <= 1'b0;
        full_q      <= 1'b0;
      end
      if (cmd_i.scan_en && cmd_i.scan_mac && mac_hit) mac_found_q <= 1'b1;
      if (cmd_i.scan_en && !cmd_i.scan_mac && s_hit) s_found_q <= 1'b1;
      if (cmd_i.scan_en && !cmd_i.scan_mac && t_hit) t_found_q <= 1'b1;
      if (cmd_i.learn) begin
        full_q <= drop;
        if (t_new) t_found_q <= 1'b1;
      end
      if (do_ins) begin
        seen_count_q <= seen_count_q + CW'(1);
        if (!s_found_q) map_count_q <= map_count_q + CW'(1);
      end
      if (cmd_i.finish) begin
        ans_q <= ans_d;
        fld_q <= fld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    cmp_idx_q <= rd_idx_q[AW-1:0];
    if (cmd_i.scan_en && !cmd_i.scan_mac && s_hit) s_idx_q <= cmp_idx_q;
    if (cmd_i.scan_en && !cmd_i.scan_mac && t_hit) t_idx_q <= cmp_idx_q;
    if (t_new) t_idx_q <= map_count_q[AW-1:0];
    if (cmd_i.finish) result_q <= result_d;
  end

  assign status_o.is_arp    = is_arp;
  assign status_o.is_req    = is_req;
  assign status_o.scan_done = scan_done;
  assign result_o           = result_q;
  assign done_o             = done_q;

endmodule

FILE: tb/arp_learning_proxy_responder_unit_tb.sv
// Self-checking testbench for the ARP learning proxy responder unit.
// Depends on apr_pkg and arp_learning_proxy_responder_unit, which needs apr_ctrl, apr_datapath and apr_ram.
// A behavioral predictor of the learning tables forms the expected results checked here.
module arp_learning_proxy_responder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apr_pkg::*;

  localparam int unsigned Depth = TableDepthDefault;
  localparam logic [15:0] OpReply = 16'h0002;
  // Longest correct silence is one full-table request plus a sender burst.
  localparam int unsigned StallLimit = 1000;
  // Quiet time after the last result, a little over the worst-case latency.
  localparam int unsigned TailCycles = 150;
  localparam int unsigned IpPoolSize = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  apr_item_t   item_i;
  logic        busy_o;
  logic        done_o;
  apr_result_t result_o;

  arp_learning_proxy_responder_unit #(
    .TableDepth(Depth)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted copy of the block's state. Only entries below the fill levels are read.
  logic [47:0] known_macs [Depth];
  int          known_mac_fill;
  logic [31:0] bind_ips   [Depth];
  logic [47:0] bind_macs  [Depth];
  int          bind_fill;
  bit   [31:0] answered_count;
  bit   [31:0] flooded_count;

  // Expected results in the order the words were accepted.
  apr_result_t pending_results [$];
  apr_result_t head_result;

  // Stimulus pools: a small set of IPs so that lookups hit, and every MAC used so far.
  logic [31:0] ip_pool [IpPoolSize];
  logic [47:0] mac_pool [$];

  bit          idle_en;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned fault_count;
  int unsigned quiet_cycles;
  int unsigned verdict_tally [4];
  int unsigned dropped_inserts;

  // Returns the map slot bound to ip, or -1 when the IP has no binding.
  function automatic int find_binding(logic [31:0] ip);
    int slot;
    slot = -1;
    for (int i = 0; i < bind_fill; i++) begin
      if (slot < 0 && bind_ips[i] == ip) slot = i;
    end
    return slot;
  endfunction

  // Applies one accepted word to the predicted tables and returns the result it must cause.
  // Learning always comes first, so a request can be answered from its own binding.
  function automatic apr_result_t resolve_arp_word(apr_item_t w);
    apr_result_t r;
    int          slot;
    bit          mac_seen;
    r = '0;
    if (w.ether_type == EtherTypeArp) begin
      r.verdict = VERDICT_LEARNED;
      mac_seen = 1'b0;
      for (int i = 0; i < known_mac_fill; i++) begin
        if (known_macs[i] == w.source_mac) mac_seen = 1'b1;
      end
      // A known MAC teaches nothing, even when it now claims another IP.
      if (!mac_seen) begin
        slot = find_binding(w.sender_ip);
        if (known_mac_fill >= Depth || (slot < 0 && bind_fill >= Depth)) begin
          r.table_full = 1'b1;
        end else begin
          known_macs[known_mac_fill] = w.source_mac;
          known_mac_fill++;
          if (slot < 0) begin
            slot = bind_fill;
            bind_ips[slot] = w.sender_ip;
            bind_fill++;
          end
          bind_macs[slot] = w.source_mac;
        end
      end
      if (w.arp_opcode == OpRequest) begin
        r.switch_out = w.switch_tag;
        slot = find_binding(w.target_ip);
        if (slot >= 0) begin
          r.verdict          = VERDICT_ANSWERED;
          r.reply_sender_ip  = w.target_ip;
          r.reply_sender_mac = bind_macs[slot];
          r.reply_target_ip  = w.sender_ip;
          r.reply_target_mac = w.source_mac;
          r.egress_port      = w.ingress_port;
          answered_count++;
        end else begin
          r.verdict = VERDICT_FLOOD;
          flooded_count++;
        end
      end
    end
    r.answered_total = answered_count;
    r.flooded_total  = flooded_count;
    verdict_tally[r.verdict]++;
    if (r.table_full) dropped_inserts++;
    return r;
  endfunction

  function automatic apr_item_t arp_word(logic [15:0] op, logic [31:0] sip, logic [31:0] tip,
                                         logic [47:0] mac, logic [15:0] port, logic [7:0] tag);
    apr_item_t w;
    w.ether_type   = EtherTypeArp;
    w.arp_opcode   = op;
    w.sender_ip    = sip;
    w.target_ip    = tip;
    w.source_mac   = mac;
    w.ingress_port = port;
    w.switch_tag   = tag;
    return w;
  endfunction

  function automatic logic [47:0] fresh_mac();
    logic [47:0] mac;
    mac = {16'($urandom), 32'($urandom)};
    mac_pool.push_back(mac);
    return mac;
  endfunction

  // Mostly well-formed ARP traffic over a small IP pool; one word in ten is not ARP.
  function automatic apr_item_t make_traffic_word();
    apr_item_t   w;
    logic [191:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(apr_item_t)-1:0];
    if ($urandom_range(0, 99) < 10) begin
      if (w.ether_type == EtherTypeArp) w.ether_type[0] = ~w.ether_type[0];
      return w;
    end
    w.ether_type = EtherTypeArp;
    pick = $urandom_range(0, 99);
    if (pick < 55) w.arp_opcode = OpRequest;
    else if (pick < 85) w.arp_opcode = OpReply;
    if ($urandom_range(0, 99) < 85) w.sender_ip = ip_pool[$urandom_range(0, IpPoolSize - 1)];
    if ($urandom_range(0, 99) < 75) w.target_ip = ip_pool[$urandom_range(0, IpPoolSize - 1)];
    // New MACs are rare so the MAC set fills only toward the end of the run.
    if (mac_pool.size() == 0 || $urandom_range(0, 99) < 6) begin
      w.source_mac = fresh_mac();
    end else begin
      w.source_mac = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
    end
    return w;
  endfunction

  task automatic note_fault(string msg);
    if (fault_count < 10) $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    fault_count++;
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) note_fault($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Result checker and acceptance tracker. Everything is sampled at the rising edge,
  // before the block's own registers update, so the values seen are the ones that
  // the edge acts on. A result of the previous word may share an edge with the
  // acceptance of the next one; the older expectation is popped first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          note_fault("result strobe with no word outstanding");
        end else begin
          head_result = pending_results.pop_front();
          compare_field("verdict", 64'(head_result.verdict), 64'(result_o.verdict));
          compare_field("reply_sender_ip", 64'(head_result.reply_sender_ip),
                        64'(result_o.reply_sender_ip));
          compare_field("reply_sender_mac", 64'(head_result.reply_sender_mac),
                        64'(result_o.reply_sender_mac));
          compare_field("reply_target_ip", 64'(head_result.reply_target_ip),
                        64'(result_o.reply_target_ip));
          compare_field("reply_target_mac", 64'(head_result.reply_target_mac),
                        64'(result_o.reply_target_mac));
          compare_field("egress_port", 64'(head_result.egress_port),
                        64'(result_o.egress_port));
          compare_field("switch_out", 64'(head_result.switch_out),
                        64'(result_o.switch_out));
          compare_field("answered_total", 64'(head_result.answered_total),
                        64'(result_o.answered_total));
          compare_field("flooded_total", 64'(head_result.flooded_total),
                        64'(result_o.flooded_total));
          compare_field("table_full", 64'(head_result.table_full),
                        64'(result_o.table_full));
        end
        results_seen++;
      end
      if (start_i && !busy_o) pending_results.push_back(resolve_arp_word(item_i));
      if (done_o || (start_i && !busy_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[%0t] no word moved for %0d cycles, %0d results outstanding", $realtime,
                 quiet_cycles, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one word from a falling edge and returns at the falling edge after it was taken,
  // with start_i still high: the caller either offers the next word or drops start_i.
  // Idle bursts go either right after the previous acceptance or into the block's idle time.
  task automatic send_word(input apr_item_t w);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      start_i <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy_o);
        @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Words that are not ARP, including near misses on the type, must leave all state alone.
  task automatic test_non_arp();
    apr_item_t w;
    w = '0;
    send_word(w);
    w = '1;
    send_word(w);
    w = arp_word(OpRequest, 32'h0a00_0001, 32'h0a00_0002, 48'h0200_0000_0001, 16'd1, 8'd1);
    w.ether_type = 16'h0807;
    send_word(w);
    w.ether_type = 16'h8806;
    send_word(w);
  endtask

  // Requests into an empty map flood, yet still teach the sender's binding.
  task automatic test_flood_unknown();
    send_word(arp_word(OpRequest, 32'h0a00_0001, 32'h0a00_0002, 48'h0200_0000_0001,
                       16'h0000, 8'h00));
    send_word(arp_word(OpRequest, 32'h0000_0000, 32'hffff_ffff, 48'hffff_ffff_ffff,
                       16'hffff, 8'hff));
  endtask

  // Learned bindings answer later requests, a request may hit its own new binding,
  // and the field extremes pass through the reply.
  task automatic test_answer_known();
    send_word(arp_word(OpReply, 32'h0a00_0002, 32'h0a00_0001, 48'h0200_0000_0002,
                       16'h1234, 8'h5a));
    send_word(arp_word(OpRequest, 32'h0a00_0003, 32'h0a00_0002, 48'h0200_0000_0003,
                       16'h8001, 8'h81));
    send_word(arp_word(OpRequest, 32'h0a00_0001, 32'h0000_0000, 48'h0200_0000_0001,
                       16'hffff, 8'hff));
    send_word(arp_word(OpRequest, 32'h0a00_0004, 32'h0a00_0004, 48'h0200_0000_0004,
                       16'h0001, 8'h01));
    send_word(arp_word(OpRequest, 32'hffff_ffff, 32'hffff_ffff, 48'h0000_0000_0000,
                       16'h7fff, 8'h7f));
  endtask

  // Any opcode other than a request is only learned from, even if its target is known.
  task automatic test_other_opcodes();
    send_word(arp_word(16'h0000, 32'h0a00_0005, 32'h0a00_0002, 48'h0200_0000_0005,
                       16'h0055, 8'h55));
    send_word(arp_word(16'hffff, 32'h0a00_0006, 32'h0a00_0002, 48'h0200_0000_0006,
                       16'haaaa, 8'haa));
    send_word(arp_word(16'h0100, 32'h0a00_0007, 32'h0a00_0002, 48'h0200_0000_0007,
                       16'h0101, 8'h10));
    send_word(arp_word(16'h0003, 32'h0a00_0008, 32'h0a00_0002, 48'h0200_0000_0002,
                       16'h0202, 8'h20));
  endtask

  // A known MAC cannot move to a new IP; a new MAC takes over an existing IP.
  task automatic test_known_mac_rebind();
    send_word(arp_word(OpReply, 32'h0a00_0009, 32'h0a00_0001, 48'h0200_0000_0002,
                       16'h0303, 8'h30));
    send_word(arp_word(OpRequest, 32'h0a00_0003, 32'h0a00_0009, 48'h0200_0000_0003,
                       16'h0404, 8'h40));
    send_word(arp_word(OpReply, 32'h0a00_0002, 32'h0a00_0001, 48'h0200_0000_000a,
                       16'h0505, 8'h50));
    send_word(arp_word(OpRequest, 32'h0a00_0001, 32'h0a00_0002, 48'h0200_0000_0001,
                       16'h0606, 8'h60));
    send_word(arp_word(OpReply, 32'h0a00_0002, 32'h0a00_0003, 48'h0200_0000_0003,
                       16'h0707, 8'h70));
    send_word(arp_word(OpRequest, 32'h0a00_0004, 32'h0a00_0002, 48'h0200_0000_0004,
                       16'h0808, 8'h80));
  endtask

  // Random traffic; idling switches on and off in stretches of forty words.
  task automatic test_random_traffic(int unsigned arp_words);
    apr_item_t   w;
    int unsigned arp_done;
    int unsigned n;
    arp_done = 0;
    n = 0;
    while (arp_done < arp_words) begin
      if (n % 40 == 0) idle_en = ($urandom_range(0, 3) != 0);
      w = make_traffic_word();
      send_word(w);
      if (w.ether_type == EtherTypeArp) arp_done++;
      n++;
    end
  endtask

  // The sender holds off until every result is in, then resumes with a short burst.
  task automatic test_quiet_pause();
    wait_results_drained();
    idle_en = 1'b0;
    repeat (6) send_word(make_traffic_word());
  endtask

  // Fills the MAC set with new senders, overflows it, then checks that lookups still
  // work on the frozen map. Runs without idling as the last part of the run.
  task automatic test_table_full();
    logic [31:0] ip;
    int unsigned tail;
    idle_en = 1'b0;
    tail = 0;
    while (known_mac_fill < Depth || tail < 12) begin
      if (known_mac_fill >= Depth) tail++;
      send_word(arp_word(($urandom_range(0, 1) == 1) ? OpRequest : OpReply, $urandom,
                         ip_pool[$urandom_range(0, IpPoolSize - 1)], fresh_mac(),
                         16'($urandom), 8'($urandom)));
    end
    // A dropped self-binding must not be visible to the request's own lookup.
    ip = $urandom;
    send_word(arp_word(OpRequest, ip, ip, fresh_mac(), 16'($urandom), 8'($urandom)));
    repeat (30) begin
      send_word(arp_word(OpRequest, ip_pool[$urandom_range(0, IpPoolSize - 1)],
                         ip_pool[$urandom_range(0, IpPoolSize - 1)],
                         mac_pool[$urandom_range(0, mac_pool.size() - 1)],
                         16'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    item_i          = '0;
    idle_en         = 1'b0;
    known_mac_fill  = 0;
    bind_fill       = 0;
    answered_count  = '0;
    flooded_count   = '0;
    words_sent      = 0;
    results_seen    = 0;
    fault_count     = 0;
    quiet_cycles    = 0;
    dropped_inserts = 0;
    for (int i = 0; i < 4; i++) verdict_tally[i] = 0;
    for (int i = 0; i < IpPoolSize; i++) ip_pool[i] = $urandom;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words run back to back, then random traffic with idling.
    test_non_arp();
    test_flood_unknown();
    test_answer_known();
    test_other_opcodes();
    test_known_mac_rebind();
    test_random_traffic(450);
    test_quiet_pause();
    test_random_traffic(450);
    test_table_full();

    wait_results_drained();
    repeat (TailCycles) @(negedge clk_i);

    $display("Covered %0d words: %0d ignored, %0d learned only, %0d answered, %0d flooded.",
             words_sent, verdict_tally[VERDICT_IGNORED], verdict_tally[VERDICT_LEARNED],
             verdict_tally[VERDICT_ANSWERED], verdict_tally[VERDICT_FLOOD]);
    $display("MAC set reached %0d of %0d, IP map %0d; %0d inserts dropped, %0d faults.",
             known_mac_fill, Depth, bind_fill, dropped_inserts, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
